// ===== rtl/clcd_pkg.sv =====
package clcd_pkg;

   // Request codes
   typedef enum logic [2:0] {
      FUNC_WRITE_CHAR = 3'd0,
      FUNC_CLEAR      = 3'd1,
      FUNC_HOME       = 3'd2,
      FUNC_GOTO       = 3'd3,
      FUNC_SHIFT_FWD  = 3'd4,
      FUNC_SHIFT_BACK = 3'd5,
      FUNC_INIT       = 3'd6,
      FUNC_RESERVED   = 3'd7
   } func_type;

   typedef enum logic {
      ST_IDLE,
      ST_EMIT
   } state_type;

   // Controller -> datapath
   typedef struct packed {
      logic load;   // capture request word
      logic step;   // produce one result word
   } ctrl_cmd_type;

   // Datapath -> controller
   typedef struct packed {
      logic req_empty;    // incoming request yields no words
      logic out_free;     // output register can take a word this cycle
      logic last_result;  // word about to be produced is the final one
   } dp_stat_type;

   localparam logic [7:0] CMD_CLEAR      = 8'h01;
   localparam logic [7:0] CMD_HOME       = 8'h02;
   localparam logic [7:0] CMD_SHIFT_FWD  = 8'h14;
   localparam logic [7:0] CMD_SHIFT_BACK = 8'h10;
   localparam int unsigned InitLen       = 5;

   // Expander low-nibble flag bits
   localparam logic [3:0] XP_DATA_EN  = 4'hD;
   localparam logic [3:0] XP_DATA     = 4'h9;
   localparam logic [3:0] XP_CMD_EN   = 4'h4;
   localparam logic [3:0] XP_CMD      = 4'h0;
   localparam logic [3:0] XP_CMD_BL   = 4'h8;

   function automatic logic [7:0] row_base(input logic [1:0] row);
      logic [7:0] base;
      case (row)
         2'd0:    base = 8'h80;
         2'd1:    base = 8'hC0;
         2'd2:    base = 8'h94;
         default: base = 8'hD4;
      endcase
      return base;
   endfunction

   function automatic logic [7:0] init_byte(input logic [2:0] idx);
      logic [7:0] b;
      case (idx)
         3'd0:    b = 8'h02;
         3'd1:    b = 8'h28;
         3'd2:    b = 8'h06;
         3'd3:    b = 8'h0C;
         3'd4:    b = 8'h01;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

// ===== rtl/clcd_if.sv =====
interface clcd_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] func;
   logic [7:0] char_code;
   logic [7:0] column;
   logic [1:0] row;
   logic [7:0] repeat_count;

   modport source (output valid, func, char_code, column, row, repeat_count,
                   input ready);
   modport sink   (input valid, func, char_code, column, row, repeat_count,
                   output ready);
endinterface

interface clcd_rsp_if;
   logic       valid;
   logic       ready;
   logic       reg_select;
   logic [3:0] nibble;
   logic [7:0] frame_a;
   logic [7:0] frame_b;
   logic [7:0] frame_c;
   logic [7:0] frame_d;
   logic       wait_after;
   logic       last;

   modport source (output valid, reg_select, nibble, frame_a, frame_b, frame_c,
                   frame_d, wait_after, last, input ready);
   modport sink   (input valid, reg_select, nibble, frame_a, frame_b, frame_c,
                   frame_d, wait_after, last, output ready);
endinterface

// ===== rtl/clcd_ctrl.sv =====
module clcd_ctrl
   import clcd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  dp_stat_type  stat,
   output ctrl_cmd_type cmd
);

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && !stat.req_empty) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (stat.out_free && stat.last_result) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_EMIT: begin
            cmd.step = stat.out_free;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/clcd_dp.sv =====
module clcd_dp
   import clcd_pkg::*;
#(
   parameter int MAX_SHIFT = 32
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_wr_en,
   input  logic         csr_wr_data,
   input  logic [2:0]   func,
   input  logic [7:0]   char_code,
   input  logic [7:0]   column,
   input  logic [1:0]   row,
   input  logic [7:0]   repeat_count,
   input  ctrl_cmd_type cmd,
   output dp_stat_type  stat,
   input  logic         rsp_ready,
   output logic         rsp_valid,
   output logic         rsp_reg_select,
   output logic [3:0]   rsp_nibble,
   output logic [7:0]   rsp_frame_a,
   output logic [7:0]   rsp_frame_b,
   output logic [7:0]   rsp_frame_c,
   output logic [7:0]   rsp_frame_d,
   output logic         rsp_wait_after,
   output logic         rsp_last
);

   localparam int CntMax = (MAX_SHIFT > InitLen) ? MAX_SHIFT : InitLen;
   localparam int CntW   = $clog2(CntMax + 1);

   // interface mode: 0 parallel nibbles, 1 expander frames
   logic            mode_ff;

   // request being worked
   func_type        func_ff,  func_in;
   logic [7:0]      chr_ff,   chr_in;
   logic [7:0]      goto_ff,  goto_in;
   logic [CntW-1:0] cnt_ff,   cnt_in;    // bytes left, current included
   logic [2:0]      idx_ff,   idx_in;    // init table position
   logic            half_ff,  half_in;   // low nibble next (parallel)

   // output register
   logic            vld_ff,   vld_in;
   logic            rs_ff;
   logic [3:0]      nib_ff;
   logic [7:0]      fa_ff, fb_ff, fc_ff, fd_ff;
   logic            wt_ff;
   logic            last_ff;

   logic [CntW-1:0] sat_cnt;
   logic [CntW-1:0] load_cnt;
   logic [7:0]      cur_byte;
   logic [3:0]      hi, lo;
   logic            is_data;
   logic            long_wait;
   logic            nib_last;

   logic            rs_w;
   logic [3:0]      nib_w;
   logic [7:0]      fa_w, fb_w, fc_w, fd_w;
   logic            wt_w;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
      end else if (csr_wr_en) begin
         mode_ff <= csr_wr_data;
      end
   end

   // saturated shift count and byte count per request
   always_comb begin
      if (repeat_count > 8'(MAX_SHIFT)) begin
         sat_cnt = CntW'(MAX_SHIFT);
      end else begin
         sat_cnt = CntW'(repeat_count);
      end
      case (func_type'(func))
         FUNC_WRITE_CHAR, FUNC_CLEAR, FUNC_HOME, FUNC_GOTO: load_cnt = CntW'(1);
         FUNC_SHIFT_FWD, FUNC_SHIFT_BACK:                   load_cnt = sat_cnt;
         FUNC_INIT:                                         load_cnt = CntW'(InitLen);
         default:                                           load_cnt = '0;
      endcase
   end

   assign stat.req_empty = (load_cnt == '0);

   // current byte and its attributes
   always_comb begin
      is_data   = 1'b0;
      long_wait = 1'b0;
      case (func_ff)
         FUNC_WRITE_CHAR: begin
            cur_byte = chr_ff;
            is_data  = 1'b1;
         end
         FUNC_CLEAR: begin
            cur_byte  = CMD_CLEAR;
            long_wait = 1'b1;
         end
         FUNC_HOME: begin
            cur_byte  = CMD_HOME;
            long_wait = 1'b1;
         end
         FUNC_GOTO:       cur_byte = goto_ff;
         FUNC_SHIFT_FWD:  cur_byte = CMD_SHIFT_FWD;
         FUNC_SHIFT_BACK: cur_byte = CMD_SHIFT_BACK;
         FUNC_INIT: begin
            cur_byte  = init_byte(idx_ff);
            long_wait = 1'b1;
         end
         default:         cur_byte = 8'h00;
      endcase
      hi = cur_byte[7:4];
      lo = cur_byte[3:0];
   end

   // format one result word
   always_comb begin
      rs_w  = is_data;
      nib_w = 4'h0;
      fa_w  = 8'h00;
      fb_w  = 8'h00;
      fc_w  = 8'h00;
      fd_w  = 8'h00;
      wt_w  = long_wait;
      if (mode_ff) begin
         if (is_data) begin
            fa_w = {hi, XP_DATA_EN};
            fb_w = {hi, XP_DATA};
            fc_w = {lo, XP_DATA_EN};
            fd_w = {lo, XP_DATA};
         end else begin
            fa_w = {hi, XP_CMD_EN};
            fb_w = {hi, XP_CMD};
            fc_w = {lo, XP_CMD_EN};
            fd_w = {lo, XP_CMD_BL};
         end
      end else begin
         nib_w = half_ff ? lo : hi;
         wt_w  = long_wait & half_ff;
      end
   end

   assign nib_last         = mode_ff || half_ff;
   assign stat.last_result = (cnt_ff == CntW'(1)) && nib_last;
   assign stat.out_free    = !vld_ff || rsp_ready;

   // work registers
   always_comb begin
      func_in = func_ff;
      chr_in  = chr_ff;
      goto_in = goto_ff;
      cnt_in  = cnt_ff;
      idx_in  = idx_ff;
      half_in = half_ff;
      if (cmd.load) begin
         func_in = func_type'(func);
         chr_in  = char_code;
         goto_in = row_base(row) + column;
         cnt_in  = load_cnt;
         idx_in  = 3'd0;
         half_in = 1'b0;
      end else if (cmd.step) begin
         if (nib_last) begin
            half_in = 1'b0;
            cnt_in  = cnt_ff - CntW'(1);
            idx_in  = idx_ff + 3'd1;
         end else begin
            half_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      func_ff <= func_in;
      chr_ff  <= chr_in;
      goto_ff <= goto_in;
      cnt_ff  <= cnt_in;
      idx_ff  <= idx_in;
      half_ff <= half_in;
   end

   always_comb begin
      vld_in = vld_ff;
      if (cmd.step) begin
         vld_in = 1'b1;
      end else if (rsp_ready) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.step) begin
         rs_ff   <= rs_w;
         nib_ff  <= nib_w;
         fa_ff   <= fa_w;
         fb_ff   <= fb_w;
         fc_ff   <= fc_w;
         fd_ff   <= fd_w;
         wt_ff   <= wt_w;
         last_ff <= stat.last_result;
      end
   end

   assign rsp_valid      = vld_ff;
   assign rsp_reg_select = rs_ff;
   assign rsp_nibble     = nib_ff;
   assign rsp_frame_a    = fa_ff;
   assign rsp_frame_b    = fb_ff;
   assign rsp_frame_c    = fc_ff;
   assign rsp_frame_d    = fd_ff;
   assign rsp_wait_after = wt_ff;
   assign rsp_last       = last_ff;

endmodule

// ===== rtl/char_lcd_command_sequencer_unit.sv =====
// Channel   Dir   Handshake        Word
// req_bus   in    valid / ready    func, char_code, column, row, repeat_count
// rsp_bus   out   valid / ready    reg_select, nibble, frame_a..d, wait_after, last
// csr_*     in    csr_wr_en        csr_wr_data = interface_mode
//
// A request is taken in the idle state, then its words leave one per cycle from
// the output register while the rsp side is not stalled (a shift of 32 in
// parallel mode gives 64 words). A request with no words leaves the sequencer idle.
// Rate is set by the sequencer's one-word-per-cycle emit loop.
// Reset (synchronous) returns to idle, drops rsp valid and selects parallel mode.
// A stalled rsp side holds the current word and pauses the sequencer.
module char_lcd_command_sequencer_unit
   import clcd_pkg::*;
#(
   parameter int MAX_SHIFT = 32   // 1..32
)
(
   input logic        clock,
   input logic        reset,
   clcd_req_if.sink   req_bus,
   clcd_rsp_if.source rsp_bus,
   input logic        csr_wr_en,
   input logic        csr_wr_data
);

   ctrl_cmd_type cmd;
   dp_stat_type  stat;
   logic         req_ready;

   // controller: idle/emit sequencing only
   clcd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   assign req_bus.ready = req_ready;

   // datapath: request capture, byte select, nibble/frame formatting, out reg
   clcd_dp #(
      .MAX_SHIFT (MAX_SHIFT)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .func           (req_bus.func),
      .char_code      (req_bus.char_code),
      .column         (req_bus.column),
      .row            (req_bus.row),
      .repeat_count   (req_bus.repeat_count),
      .cmd            (cmd),
      .stat           (stat),
      .rsp_ready      (rsp_bus.ready),
      .rsp_valid      (rsp_bus.valid),
      .rsp_reg_select (rsp_bus.reg_select),
      .rsp_nibble     (rsp_bus.nibble),
      .rsp_frame_a    (rsp_bus.frame_a),
      .rsp_frame_b    (rsp_bus.frame_b),
      .rsp_frame_c    (rsp_bus.frame_c),
      .rsp_frame_d    (rsp_bus.frame_d),
      .rsp_wait_after (rsp_bus.wait_after),
      .rsp_last       (rsp_bus.last)
   );

`ifndef NO_ASSERTIONS
   // no new request while words of the current one are being produced
   a_no_accept_in_emit: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> !req_bus.ready)
      else $error("request accepted during emit");

   // final word produced: sequencer is back for the next request
   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      (cmd.step && stat.last_result) |=> req_bus.ready)
      else $error("not idle after last word");

   // a request with no words never leaves idle
   a_empty_stays_idle: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready && stat.req_empty) |=> req_bus.ready)
      else $error("empty request started emit");

   // a parallel nibble word carries no expander frames
   a_nibble_no_frames: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.nibble != 4'h0) |->
         (rsp_bus.frame_a == 8'h00 && rsp_bus.frame_d == 8'h00))
      else $error("nibble and frames both set");
`endif

endmodule
